/* rtl/core/miir_pkg.sv */
// Shared types and constants for the multichannel IIR filter.
`timescale 1ns / 1ps
package miir_pkg;
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 27;
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_ORDER  = 3'd1,
        REG_B0B1   = 3'd2,
        REG_B2B3   = 3'd3,
        REG_B4A1   = 3'd4,
        REG_A2A3   = 3'd5,
        REG_A4     = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DONE
    } t_state;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
endpackage

/* rtl/core/miir_stream_if.sv */
// Valid/ready stream interface carrying a payload of W bits.
`timescale 1ns / 1ps
interface miir_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/multichannel_iir_filter_order4.sv */
// Top level of the multichannel direct form I IIR filter.
`timescale 1ns / 1ps
// Direct form I IIR filter, order 0..MAX_ORDER, per-channel delay lines.
// Input transaction data = {channel, sample_in}; output = {saturated,
// sample_out}. One transaction is handled at a time: a filtered sample takes
// 2*order+1 multiply steps of one shared multiplier, each step a serial
// shift-add over the 24 sample bits, one bit per cycle. A new transaction is
// accepted only after the previous result has gone to the output register;
// bypassed samples skip the multiply steps and can follow back to back
// while the output is taken. Results are held in an output register until
// taken. Coefficients must be written by the user only while idle; the
// block itself does not enforce this.
module multichannel_iir_filter_order4 #(
    parameter int CHANNELS  = 2,
    parameter int MAX_ORDER = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [miir_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [miir_pkg::CFG_W-1:0]  i_cfg_data,
    miir_stream_if.sink                 i_s,
    miir_stream_if.source               o_m
);
    import miir_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int STEP_W = $clog2(2*MAX_ORDER+2);
    localparam int BIT_W = $clog2(SAMPLE_W);

    // configuration
    logic           r_en;
    logic [2:0]     r_order;
    t_coef          r_b [0:4];
    t_coef          r_a [1:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_order <= 3'd1;
            for (int i = 0; i < 5; i++) r_b[i] <= '0;
            for (int i = 1; i < 5; i++) r_a[i] <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE: r_en <= i_cfg_data[0];
                REG_ORDER:  r_order <= i_cfg_data[2:0];
                REG_B0B1: begin r_b[0] <= i_cfg_data[31:0]; r_b[1] <= i_cfg_data[63:32]; end
                REG_B2B3: begin r_b[2] <= i_cfg_data[31:0]; r_b[3] <= i_cfg_data[63:32]; end
                REG_B4A1: begin r_b[4] <= i_cfg_data[31:0]; r_a[1] <= i_cfg_data[63:32]; end
                REG_A2A3: begin r_a[2] <= i_cfg_data[31:0]; r_a[3] <= i_cfg_data[63:32]; end
                REG_A4:   r_a[4] <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // delay lines, tap k of channel c at index [c][k]
    t_sample r_xh [CHANNELS][MAX_ORDER];
    t_sample r_yh [CHANNELS][MAX_ORDER];

    t_state  r_state, n_state;
    logic [CH_W-1:0]   r_ch;
    t_sample           r_x;
    logic [STEP_W-1:0] r_step;   // 0 = b0*x, odd = b tap, even = a tap
    logic [STEP_W-1:0] r_nsteps;
    logic [BIT_W-1:0]  r_bit;
    t_sample           r_mul_s;  // sample being shifted out bit-serially
    logic signed [ACC_W-1:0] r_coef_sh; // coefficient shifted left per bit
    logic signed [ACC_W-1:0] r_acc;
    logic [SAMPLE_W-1:0] r_out;
    logic                r_sat;
    logic                r_ovalid;
    logic [2:0]          w_ord;

    assign w_ord = (r_order > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : r_order;

    logic             w_is_a;
    assign w_is_a = (r_step != '0) && !r_step[0];

    // rounding and saturation of the accumulator
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-FRAC_W-1:0] w_q;
    logic [SAMPLE_W-1:0] w_y;
    logic w_sat;
    always_comb begin
        w_rnd = r_acc + (ACC_W'(1) <<< (FRAC_W-1));
        w_q   = w_rnd[ACC_W-1:FRAC_W];
        w_sat = 1'b1;
        if (w_q > (ACC_W-FRAC_W)'(signed'(24'sh7FFFFF)))
            w_y = 24'h7FFFFF;
        else if (w_q < (ACC_W-FRAC_W)'(signed'(-24'sh800000)))
            w_y = 24'h800000;
        else begin
            w_y = w_q[SAMPLE_W-1:0];
            w_sat = 1'b0;
        end
    end

    logic w_last_bit, w_last_step, w_acc_in, w_bypass, w_load;
    assign w_last_bit  = (r_bit == BIT_W'(SAMPLE_W-1));
    assign w_last_step = (r_step == r_nsteps);
    assign w_acc_in    = i_s.valid && i_s.ready;
    assign w_bypass    = !r_en || (32'(i_s.data[SAMPLE_W]) >= CHANNELS);
    // load the output register with a bypassed or a finished sample
    assign w_load = ((r_state == ST_IDLE) && w_acc_in && w_bypass) ||
                    ((r_state == ST_DONE) && (!r_ovalid || o_m.ready));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc_in && !w_bypass) n_state = ST_MAC;
            ST_MAC:  if (w_last_bit && w_last_step) n_state = ST_DONE;
            ST_DONE: if (!r_ovalid || o_m.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_s.ready = (r_state == ST_IDLE) && (!r_ovalid || o_m.ready);
    end
    assign o_m.valid = r_ovalid;
    assign o_m.data  = {r_sat, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
                for (int k = 0; k < MAX_ORDER; k++) begin
                    r_xh[c][k] <= '0;
                    r_yh[c][k] <= '0;
                end
        end else begin
            r_state <= n_state;
            if (w_load)
                r_ovalid <= 1'b1;
            else if (o_m.ready)
                r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: if (w_acc_in) begin
                    if (w_bypass) begin
                        r_out    <= i_s.data[SAMPLE_W-1:0];
                        r_sat    <= 1'b0;
                    end else begin
                        r_ch      <= CH_W'(i_s.data[SAMPLE_W]);
                        r_x       <= i_s.data[SAMPLE_W-1:0];
                        r_mul_s   <= i_s.data[SAMPLE_W-1:0];
                        r_coef_sh <= ACC_W'(r_b[0]);
                        r_step    <= '0;
                        r_nsteps  <= STEP_W'({w_ord, 1'b0});
                        r_bit     <= '0;
                        r_acc     <= '0;
                    end
                end
                ST_MAC: begin
                    // one partial product a cycle; sign bit weighs negative
                    logic signed [ACC_W-1:0] pp;
                    logic [STEP_W-1:0] ns;
                    logic [TAP_W-1:0]  nt;
                    pp = r_mul_s[0] ? r_coef_sh : '0;
                    if (w_last_bit) pp = -pp;
                    if (w_is_a) pp = -pp;
                    ns = r_step + STEP_W'(1);
                    nt = TAP_W'((ns - STEP_W'(1)) >> 1);
                    r_acc     <= r_acc + pp;
                    r_bit     <= w_last_bit ? '0 : r_bit + BIT_W'(1);
                    if (w_last_bit && !w_last_step) begin
                        // reload multiplicand and coefficient for the next step
                        r_step    <= ns;
                        r_mul_s   <= ns[0] ? r_xh[r_ch][nt] : r_yh[r_ch][nt];
                        r_coef_sh <= ACC_W'(ns[0] ? r_b[3'(nt)+3'd1] : r_a[3'(nt)+3'd1]);
                    end else begin
                        r_mul_s   <= r_mul_s >>> 1;
                        r_coef_sh <= r_coef_sh <<< 1;
                    end
                end
                ST_DONE: if (!r_ovalid || o_m.ready) begin
                    r_out    <= w_y;
                    r_sat    <= w_sat;
                    for (int k = MAX_ORDER-1; k > 0; k--)
                        if (k < 32'(w_ord)) begin
                            r_xh[r_ch][k] <= r_xh[r_ch][k-1];
                            r_yh[r_ch][k] <= r_yh[r_ch][k-1];
                        end
                    r_xh[r_ch][0] <= r_x;
                    r_yh[r_ch][0] <= t_sample'(w_y);
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s.ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m.valid && !o_m.ready) |=> $stable(o_m.data)) else $error("output changed");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MAC |-> r_step <= r_nsteps) else $error("step overrun");
endmodule

/* sim/miir_checker.sv */
// Checker for the multichannel IIR filter: predicts each result and compares it.
`timescale 1ns / 1ps
module miir_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [24:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [24:0] i_out_data,
    output int          o_errors,
    output int          o_pending
);
    import miir_pkg::*;

    typedef struct packed {
        logic    sat;
        t_sample y;
    } t_filt_result;

    logic [63:0]  cfg_regs [0:6];
    t_sample      x_taps [0:1][0:3];
    t_sample      y_taps [0:1][0:3];
    t_filt_result filt_queue [$];

    assign o_pending = filt_queue.size();

    function automatic longint coef_at(int k_b, int hi);
        logic [31:0] w;
        w = hi ? cfg_regs[k_b][63:32] : cfg_regs[k_b][31:0];
        return longint'($signed(w));
    endfunction

    // Filter one sample and advance the channel's delay lines.
    task automatic filter_sample(input logic [24:0] d);
        longint       b [0:4];
        longint       a [1:4];
        longint       acc;
        longint       y;
        logic [63:0]  u;
        int           ord;
        int           ch;
        t_filt_result r;
        t_sample      x;
        x  = d[23:0];
        ch = d[24];
        r.sat = 1'b0;
        if (cfg_regs[REG_ENABLE][0] == 1'b0) begin
            r.y = x;
            filt_queue.push_back(r);
            return;
        end
        ord = cfg_regs[REG_ORDER][2:0];
        if (ord > 4) ord = 4;
        b[0] = coef_at(REG_B0B1, 0); b[1] = coef_at(REG_B0B1, 1);
        b[2] = coef_at(REG_B2B3, 0); b[3] = coef_at(REG_B2B3, 1);
        b[4] = coef_at(REG_B4A1, 0); a[1] = coef_at(REG_B4A1, 1);
        a[2] = coef_at(REG_A2A3, 0); a[3] = coef_at(REG_A2A3, 1);
        a[4] = coef_at(REG_A4, 0);
        acc = b[0] * longint'(x);
        for (int k = 0; k < ord; k++) begin
            acc += b[k+1] * longint'(x_taps[ch][k]);
            acc -= a[k+1] * longint'(y_taps[ch][k]);
        end
        // round half up: bias to nonnegative, shift, remove bias
        u = acc + (64'd1 << 26) + (64'd1 << 59);
        y = longint'(u >> 27) - (64'sd1 <<< 32);
        if (y > 8388607) begin
            y = 8388607; r.sat = 1'b1;
        end else if (y < -8388608) begin
            y = -8388608; r.sat = 1'b1;
        end
        r.y = y[23:0];
        for (int k = ord - 1; k > 0; k--) begin
            x_taps[ch][k] = x_taps[ch][k-1];
            y_taps[ch][k] = y_taps[ch][k-1];
        end
        x_taps[ch][0] = x;
        y_taps[ch][0] = r.y;
        filt_queue.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_filt_result want;
        t_filt_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < 7; i++) cfg_regs[i] = '0;
            cfg_regs[REG_ORDER] = 64'd1;
            for (int c = 0; c < 2; c++)
                for (int k = 0; k < 4; k++) begin
                    x_taps[c][k] = '0;
                    y_taps[c][k] = '0;
                end
            filt_queue.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we && i_cfg_idx <= REG_A4) begin
                case (i_cfg_idx)
                    REG_ENABLE: cfg_regs[i_cfg_idx] = i_cfg_data & 64'd1;
                    REG_ORDER:  cfg_regs[i_cfg_idx] = i_cfg_data & 64'd7;
                    REG_A4:     cfg_regs[i_cfg_idx] = i_cfg_data & 64'hFFFF_FFFF;
                    default:    cfg_regs[i_cfg_idx] = i_cfg_data;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (filt_queue.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result y=%0d sat=%0b", got.y, got.sat);
                end else begin
                    want = filt_queue.pop_front();
                    if (want.y !== got.y || want.sat !== got.sat) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected y=%0d sat=%0b, got y=%0d sat=%0b",
                                     want.y, want.sat, got.y, got.sat);
                    end
                end
            end
            if (i_in_valid && i_in_ready) filter_sample(i_in_data);
        end
    end
endmodule

/* sim/multichannel_iir_filter_order4_tb.sv */
// Testbench top for the multichannel IIR filter: stimulus, idling and verdict.
`timescale 1ns / 1ps
module multichannel_iir_filter_order4_tb;
    import miir_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [63:0] cfg_data = '0;
    int          errors;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    bit          done = 1'b0;

    miir_stream_if #(.W(25)) s_in ();
    miir_stream_if #(.W(25)) s_out ();

    always #6 i_clk = ~i_clk;

    multichannel_iir_filter_order4 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_s(s_in.sink), .o_m(s_out.source)
    );

    miir_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
        .i_in_data(s_in.data), .i_out_valid(s_out.valid), .i_out_ready(s_out.ready),
        .i_out_data(s_out.data), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        s_in.valid  = 1'b0;
        s_in.data   = '0;
        s_out.ready = 1'b0;
    end

    // Receiver: stall at random, or hold off completely during the pressure stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            s_out.ready <= 1'b0;
        else
            s_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Write one register at a clock edge.
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one transaction and hold it until accepted; valid stays up after.
    task automatic send_sample(input logic ch, input logic [23:0] x);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data  <= {ch, x};
        do @(posedge i_clk); while (!s_in.ready);
    endtask

    // Drop valid, wait for every expected result, then let the block settle.
    task automatic drain();
        s_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random sample: mostly modest levels, sometimes full scale.
    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0:       return 24'($urandom);
            1:       return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            default: return 24'($signed(16'($urandom)));
        endcase
    endfunction

    // Random coefficient, mostly a small stable-ish value in Q4.27.
    function automatic logic [31:0] rand_coef(input bit wild);
        if (wild) return $urandom;
        return 32'($signed(26'($urandom)));
    endfunction

    task automatic load_coefs(input bit wild);
        write_reg(REG_B0B1, {rand_coef(wild), rand_coef(wild)});
        write_reg(REG_B2B3, {rand_coef(wild), rand_coef(wild)});
        write_reg(REG_B4A1, {rand_coef(wild), rand_coef(wild)});
        write_reg(REG_A2A3, {rand_coef(wild), rand_coef(wild)});
        write_reg(REG_A4, {32'hFFFF_FFFF, rand_coef(wild)});
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: bypass at reset, extremes of sample and channel.
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b0, 24'h000000);
        send_sample(1'b1, 24'hFFFFFF);
        drain();
        // Unity gain at order 0: b0 = 1.0.
        write_reg(REG_ENABLE, 64'd1);
        write_reg(REG_ORDER, 64'd0);
        write_reg(REG_B0B1, {32'h0800_0000, 32'h0800_0000});
        send_sample(1'b0, 24'h123456);
        send_sample(1'b1, 24'h800000);
        drain();
        // Gain above 1 and extreme coefficients force saturation both ways.
        write_reg(REG_B0B1, {32'h8000_0000, 32'h7FFF_FFFF});
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b0, 24'h800000);
        drain();
        // Half-LSB rounding ties: b0 = 0.5.
        write_reg(REG_B0B1, {32'h0, 32'h0400_0000});
        send_sample(1'b1, 24'h000001);
        send_sample(1'b1, 24'hFFFFFF);
        send_sample(1'b1, 24'hFFFFFD);
        drain();
        // Orders above the maximum clamp to it; extreme feedback.
        write_reg(REG_ORDER, 64'd7);
        write_reg(REG_B2B3, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_B4A1, {32'h8000_0000, 32'h7FFF_FFFF});
        write_reg(REG_A2A3, {32'h7FFF_FFFF, 32'h8000_0000});
        write_reg(REG_A4, 64'h8000_0000);
        for (int i = 0; i < 6; i++) send_sample(i[0], i[1] ? 24'h7FFFFF : 24'h800000);
        drain();

        // Random phases: order, coefficients and idling vary per phase.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_ENABLE, (ph % 5 == 4) ? 64'd0 : 64'd1);
            write_reg(REG_ORDER, (ph < 2) ? 64'(ph * 4) : 64'($urandom_range(7)));
            load_coefs(ph % 3 == 2);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int i = 0; i < 43; i++) send_sample(1'($urandom_range(1)), rand_sample());
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_sample(1'($urandom_range(1)), rand_sample());
        join
        drain();
        repeat (300) @(posedge i_clk);
        done = 1'b1;
    end

    initial begin
        wait (done);
        @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("multichannel_iir_filter_order4 test passed");
        else
            $display("multichannel_iir_filter_order4 test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("multichannel_iir_filter_order4 test failed");
        $finish;
    end
endmodule
